@@ hw/rtl/pcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants for the prefix code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOLS      = 256;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PAD   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

endpackage

`default_nettype wire

@@ hw/rtl/prefix_code_bit_packer.sv @@
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Prefix code encoder with an MSB-first byte packer.
//
// Usage: drive i_op and the payload with start high; the item transfers on a
// rising edge where start is high and busy is low. Load items write one entry
// of the code table and give no result. Encode items read the table (a
// registered read), then a shifter moves up to 8 code bits per cycle into
// the bit buffer, emitting a data byte whenever a full buffer meets another
// bit. A finish with bits buffered flushes them, then emits the pad count.
// Results appear on o_out_byte/o_kind/o_last for one cycle with o_strobe;
// o_last marks the final result of an item. The receiver cannot stall.
// Load and unused op items complete at the transfer edge; a finish with an
// empty buffer gives no result, else it sends the flushed byte and then the
// pad count; a missing code passes the table read to an error; encode
// reads the table and then packs one group of up to 8 bits that fits the
// buffer per step. The first result is registered at the transfer edge for
// finish, in ST_LOOKUP for a missing code and in ST_PACK for encode.
// Reset clears the buffer and marks every table entry invalid at once.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_bit_packer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_op,
    input  wire logic [pcbp_pkg::SYM_W-1:0]  i_symbol,
    input  wire logic [pcbp_pkg::LEN_W-1:0]  i_code_len,
    input  wire logic [pcbp_pkg::CODE_W-1:0] i_code_word,
    output logic                             o_strobe,
    output logic [pcbp_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [1:0]                       o_kind,
    output logic                             o_last
);
    import pcbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PACK,
        ST_PAD
    } t_state;

    t_state               r_state;
    logic [SYMBOLS-1:0]   r_valid;
    logic [BYTE_W-1:0]    r_buf;
    logic [CNT_W-1:0]     r_cnt;
    logic [CODE_W-1:0]    r_code;
    logic [LEN_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_pad;
    logic                 r_hit;

    logic [LEN_W+CODE_W-1:0] mem [SYMBOLS];
    logic [LEN_W+CODE_W-1:0] r_rd;

    logic                 accept;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [LEN_W-1:0]     len_sat;
    logic                 wr_en;
    logic [LEN_W-1:0]     rd_len;
    logic [CODE_W-1:0]    rd_code;
    logic                 full;
    logic [CNT_W-1:0]     room;
    logic [CNT_W-1:0]     k;
    logic [BYTE_W-1:0]    bits;
    logic [2*BYTE_W-1:0]  buf_shift;
    logic [CNT_W-1:0]     flush_sh;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_symbol} < (SYM_W+1)'(SYMBOLS));
    assign idx      = i_symbol[IDX_W-1:0];
    assign len_sat  = (i_code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_code_len;
    assign wr_en    = accept && (t_op'(i_op) == OP_LOAD) && in_range;
    assign rd_len   = r_rd[LEN_W+CODE_W-1:CODE_W];
    assign rd_code  = r_rd[CODE_W-1:0];

    assign full      = (r_cnt == CNT_W'(BYTE_W));
    assign room      = full ? CNT_W'(BYTE_W) : (CNT_W'(BYTE_W) - r_cnt);
    assign k         = (r_rem < {{(LEN_W-CNT_W){1'b0}}, room}) ? r_rem[CNT_W-1:0] : room;
    assign bits      = r_code[CODE_W-1:CODE_W-BYTE_W] >> (CNT_W'(BYTE_W) - k);
    assign buf_shift = {{BYTE_W{1'b0}}, (full ? {BYTE_W{1'b0}} : r_buf)} << k;
    assign flush_sh  = CNT_W'(BYTE_W) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[idx] <= {len_sat, i_code_word};
        end
        if (accept) begin
            r_rd <= mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (t_op'(i_op))
                            OP_LOAD: begin
                                if (in_range) begin
                                    r_valid[idx] <= (len_sat != '0);
                                end
                            end
                            OP_ENCODE: begin
                                r_hit   <= in_range && r_valid[idx];
                                r_state <= ST_LOOKUP;
                            end
                            OP_FINISH: begin
                                if (r_cnt != '0) begin
                                    o_strobe   <= 1'b1;
                                    o_out_byte <= r_buf << flush_sh;
                                    o_kind     <= KIND_DATA;
                                    o_last     <= 1'b0;
                                    r_pad      <= flush_sh;
                                    r_buf      <= '0;
                                    r_cnt      <= '0;
                                    r_state    <= ST_PAD;
                                end
                            end
                            OP_NONE: begin
                            end
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    if (!r_hit) begin
                        o_strobe   <= 1'b1;
                        o_out_byte <= '0;
                        o_kind     <= KIND_ERROR;
                        o_last     <= 1'b1;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_code  <= rd_code << (LEN_W'(CODE_W) - rd_len);
                        r_rem   <= rd_len;
                        r_state <= ST_PACK;
                    end
                end
                ST_PACK: begin
                    if (full) begin
                        o_strobe   <= 1'b1;
                        o_out_byte <= r_buf;
                        o_kind     <= KIND_DATA;
                        o_last     <= (r_rem == {{(LEN_W-CNT_W){1'b0}}, k});
                    end
                    r_buf  <= buf_shift[BYTE_W-1:0] | bits;
                    r_cnt  <= (full ? '0 : r_cnt) + k;
                    r_code <= r_code << k;
                    r_rem  <= r_rem - {{(LEN_W-CNT_W){1'b0}}, k};
                    if (r_rem == {{(LEN_W-CNT_W){1'b0}}, k}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    o_strobe   <= 1'b1;
                    o_out_byte <= {{(BYTE_W-CNT_W){1'b0}}, r_pad};
                    o_kind     <= KIND_PAD;
                    o_last     <= 1'b1;
                    r_state    <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ bench/prefix_code_bit_packer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_tb
// Self-checking bench for the prefix code bit packer. A directed sequence
// covers table loads, length saturation, code masking, missing codes,
// full-buffer packing, four-byte encodes, empty and full finishes and the
// unused op. It is followed by random load/encode/finish traffic. Every
// accepted item runs through a local packer model, and each strobed output
// byte is checked in order against the bytes that model predicts.
// ----------------------------------------------------------------------------

module prefix_code_bit_packer_tb;

    import pcbp_pkg::*;

    typedef struct {
        t_op         op;
        logic [7:0]  sym;
        logic [5:0]  len;
        logic [31:0] word;
    } t_pack_item;

    typedef struct {
        logic [7:0] value;
        t_kind      kind;
        logic       last;
    } t_packed_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_op        = OP_NONE;
    logic [7:0]  i_symbol    = '0;
    logic [5:0]  i_code_len  = '0;
    logic [31:0] i_code_word = '0;
    logic        busy;
    logic        o_strobe;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic        o_last;

    t_pack_item   items_pending[$];
    t_packed_byte bytes_due[$];
    t_pack_item   cur_item;
    int           n_items;
    int           n_popped;
    int           n_accepted;
    int           idle_pct;
    int           mismatches;

    // local copy of the code table and bit buffer
    logic        code_ok[SYMBOLS];
    logic [5:0]  code_len_tbl[SYMBOLS];
    logic [31:0] code_bits_tbl[SYMBOLS];
    logic [7:0]  pack_buf;
    logic [3:0]  pack_cnt;

    prefix_code_bit_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_symbol    (i_symbol),
        .i_code_len  (i_code_len),
        .i_code_word (i_code_word),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_item(input t_op op, input logic [7:0] sym, input logic [5:0] len,
                            input logic [31:0] word);
        t_pack_item it;
        it.op   = op;
        it.sym  = sym;
        it.len  = len;
        it.word = word;
        items_pending = {items_pending, it};
    endtask

    task automatic pack_item(input t_pack_item it);
        t_packed_byte res[4];
        int           n;
        int           len;
        n = 0;
        case (it.op)
            OP_LOAD: begin
                if (int'(it.sym) < SYMBOLS) begin
                    len = int'(it.len);
                    if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
                    if (len > CODE_W) len = CODE_W;
                    code_ok[it.sym]       = (len != 0);
                    code_len_tbl[it.sym]  = 6'(len);
                    code_bits_tbl[it.sym] = (len >= 32) ? it.word
                                          : it.word & ((32'd1 << len) - 32'd1);
                end
            end
            OP_ENCODE: begin
                if (int'(it.sym) >= SYMBOLS || !code_ok[it.sym]) begin
                    res[0] = '{8'd0, KIND_ERROR, 1'b1};
                    n = 1;
                end else begin
                    for (int i = int'(code_len_tbl[it.sym]); i > 0; i--) begin
                        if (pack_cnt >= 4'd8) begin
                            res[n] = '{pack_buf, KIND_DATA, 1'b0};
                            n = n + 1;
                            pack_buf = '0;
                            pack_cnt = '0;
                        end
                        pack_buf = {pack_buf[6:0], code_bits_tbl[it.sym][i-1]};
                        pack_cnt = pack_cnt + 4'd1;
                    end
                    if (n > 0) res[n-1].last = 1'b1;
                end
            end
            OP_FINISH: begin
                if (pack_cnt != 4'd0) begin
                    res[0] = '{8'(pack_buf << (4'd8 - pack_cnt)), KIND_DATA, 1'b0};
                    res[1] = '{8'(4'd8 - pack_cnt), KIND_PAD, 1'b1};
                    n = 2;
                    pack_buf = '0;
                    pack_cnt = '0;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) bytes_due = {bytes_due, res[k]};
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pack_item(cur_item);
                n_accepted = n_accepted + 1;
            end
            if (!start || !busy) begin
                idle_pct = (n_popped < n_items / 3) ? 35 :
                           (n_popped < 2 * n_items / 3) ? 57 : 0;
                if (items_pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_item = items_pending.pop_front();
                    n_popped = n_popped + 1;
                    start       <= 1'b1;
                    i_op        <= cur_item.op;
                    i_symbol    <= cur_item.sym;
                    i_code_len  <= cur_item.len;
                    i_code_word <= cur_item.word;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_packed_byte due;
        if (i_rst_n && o_strobe) begin
            if (bytes_due.size() == 0) begin
                $display("%0t: unexpected transfer out_byte %02h kind %0d last %0d",
                         $time, o_out_byte, o_kind, o_last);
                mismatches = mismatches + 1;
            end else begin
                due = bytes_due.pop_front();
                if (o_out_byte !== due.value) begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, due.value, o_out_byte);
                    mismatches = mismatches + 1;
                end
                if (o_kind !== due.kind) begin
                    $display("%0t: kind expected %0d, got %0d", $time, due.kind, o_kind);
                    mismatches = mismatches + 1;
                end
                if (o_last !== due.last) begin
                    $display("%0t: last expected %0d, got %0d", $time, due.last, o_last);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int counted;
        int r;
        int sym;
        int len;
        n_popped   = 0;
        n_accepted = 0;
        mismatches = 0;
        idle_pct   = 0;
        pack_buf   = '0;
        pack_cnt   = '0;
        for (int s = 0; s < SYMBOLS; s++) begin
            code_ok[s]       = 1'b0;
            code_len_tbl[s]  = '0;
            code_bits_tbl[s] = '0;
        end

        // directed
        add_item(OP_ENCODE, 8'd0, 6'd0, 32'd0);              // empty table
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);              // nothing buffered
        add_item(OP_LOAD, 8'd0, 6'd1, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 8'd255, 6'd32, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 8'd1, 6'd63, 32'hA5A5_A5A5);       // saturates to 32
        add_item(OP_LOAD, 8'd2, 6'd8, 32'h0000_01FF);        // upper bits dropped
        add_item(OP_LOAD, 8'd3, 6'd33, 32'h0000_0000);
        add_item(OP_ENCODE, 8'd0, 6'd0, 32'd0);
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);              // seven pad bits
        add_item(OP_ENCODE, 8'd2, 6'd0, 32'd0);              // fills buffer, no byte
        add_item(OP_ENCODE, 8'd2, 6'd0, 32'd0);
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);              // full byte, zero pad
        add_item(OP_ENCODE, 8'd0, 6'd0, 32'd0);
        add_item(OP_ENCODE, 8'd255, 6'd0, 32'd0);            // four bytes out
        add_item(OP_ENCODE, 8'd1, 6'd0, 32'd0);
        add_item(OP_ENCODE, 8'd3, 6'd0, 32'd0);
        add_item(OP_LOAD, 8'd4, 6'd5, 32'h0000_0015);
        add_item(OP_LOAD, 8'd4, 6'd0, 32'h0000_0015);        // invalidate
        add_item(OP_ENCODE, 8'd4, 6'd0, 32'd0);              // missing code
        add_item(OP_NONE, 8'hAA, 6'h3F, 32'hFFFF_FFFF);
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);
        add_item(OP_LOAD, 8'd128, 6'd31, 32'h8000_0001);
        add_item(OP_ENCODE, 8'd128, 6'd0, 32'd0);
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);

        // random
        for (int s = 0; s < 16; s++)
            add_item(OP_LOAD, 8'(s), 6'($urandom_range(1, 16)), $urandom);
        counted = 0;
        while (counted < 309) begin
            r   = $urandom_range(0, 99);
            sym = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 255);
            if (r < 15) begin
                r = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(1, 10) : (r < 90) ? $urandom_range(11, 32) :
                      (r < 95) ? 0 : $urandom_range(33, 63);
                add_item(OP_LOAD, 8'(sym), 6'(len), $urandom);
                counted++;
            end else if (r < 75) begin
                add_item(OP_ENCODE, 8'(sym), 6'($urandom_range(0, 63)), $urandom);
                counted++;
            end else if (r < 92) begin
                add_item(OP_FINISH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         $urandom);
                counted++;
            end else if (r < 97) begin
                add_item(OP_NONE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         $urandom);
                counted++;
            end else begin
                add_item(OP_ENCODE, 8'($urandom_range(0, 255)), 6'd0, 32'd0);
                counted++;
            end
        end
        add_item(OP_FINISH, 8'd0, 6'd0, 32'd0);
        n_items = items_pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items) @(posedge i_clk);
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pcbp_pkg.sv
hw/rtl/prefix_code_bit_packer.sv
bench/prefix_code_bit_packer_tb.sv
